// ----- rtl/gmpc_pkg.sv -----
`timescale 1ns / 1ps
package gmpc_pkg;

    localparam int DEF_MAX_CLASSES = 16;
    localparam int DEF_MAX_BANDS   = 8;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int MEAN_BITS  = 25;
    localparam int WORD_BITS  = 32;
    localparam int LABEL_BITS = 16;
    localparam int NUM_BITS   = 4;
    localparam int SCORE_BITS = 48;
    localparam int INV_SHIFT  = 32;

    localparam logic [2:0] CMD_SAMPLE = 3'd0;
    localparam logic [2:0] CMD_MEAN   = 3'd1;
    localparam logic [2:0] CMD_INV    = 3'd2;
    localparam logic [2:0] CMD_DET    = 3'd3;
    localparam logic [2:0] CMD_PRIOR  = 3'd4;
    localparam logic [2:0] CMD_LABEL  = 3'd5;

    localparam logic REG_CLASSES = 1'b0;
    localparam logic REG_BANDS   = 1'b1;

    typedef struct packed {
        logic mul_en;
        logic sel_aux;
        logic acc_en;
        logic acc_clr;
        logic dist_en;
        logic dist_clr;
    } mac_ctrl_t;

endpackage

// ----- rtl/gmpc_mac.sv -----
`timescale 1ns / 1ps
module gmpc_mac
    import gmpc_pkg::*;
#(
    parameter int DW    = 26,
    parameter int AUXW  = 30,
    parameter int ACC1W = 62,
    parameter int DISTW = 62
)
(
    input  logic                    clk,
    input  mac_ctrl_t               ctrl,
    input  logic signed [DW-1:0]    d_op,
    input  logic signed [WORD_BITS-1:0] inv_word,
    output logic signed [DISTW-1:0] dist_sum
);

    localparam int MW = (AUXW > WORD_BITS) ? AUXW : WORD_BITS;
    localparam int PW = DW + MW;

    logic signed [PW-1:0]    prod_reg;
    logic signed [ACC1W-1:0] acc1_reg;
    logic signed [DISTW-1:0] dist_reg;
    logic signed [AUXW-1:0]  aux;
    logic signed [MW-1:0]    b_op;

    assign aux      = acc1_reg[ACC1W-1:INV_SHIFT];
    assign b_op     = ctrl.sel_aux ? MW'(aux) : MW'(inv_word);
    assign dist_sum = dist_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= PW'(d_op) * PW'(b_op);
        end
        if (ctrl.acc_clr)
        begin
            acc1_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc1_reg <= acc1_reg + ACC1W'(prod_reg);
        end
        if (ctrl.dist_clr)
        begin
            dist_reg <= '0;
        end
        else if (ctrl.dist_en)
        begin
            dist_reg <= dist_reg + DISTW'(prod_reg);
        end
    end

endmodule

// ----- rtl/gaussian_map_pixel_classifier.sv -----
`timescale 1ns / 1ps
// Gaussian maximum a posteriori pixel classifier. Table writes (tuser = command) load per-class
// means, inverse covariance entries, determinant terms, log priors and labels; band samples
// then arrive one per transfer, and the last band in use starts scoring every class in use
// on one shared multiplier with registered mean and inverse covariance reads. Table writes and
// other band samples are taken only while idle: the input is not ready while a pixel is
// scored, and the result waits in an output register.
module gaussian_map_pixel_classifier
    import gmpc_pkg::*;
#(
    parameter int MAX_CLASSES = DEF_MAX_CLASSES,
    parameter int MAX_BANDS   = DEF_MAX_BANDS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // class_slot[3:0], dim_row[6:4], dim_col[9:7], table_word[41:10], band_sample
    input  logic [((42 + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // command[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // class_label[15:0], class_number[19:16], best_score[67:20]
    output logic [71:0] m_tdata
);

    localparam int BIW   = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int CIW   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int BCW   = $clog2(MAX_BANDS + 1);
    localparam int CCW   = $clog2(MAX_CLASSES + 1);
    localparam int MEAN_DEPTH = MAX_CLASSES * MAX_BANDS;
    localparam int INV_DEPTH  = MAX_CLASSES * MAX_BANDS * MAX_BANDS;
    localparam int MEAN_AW = $clog2(MEAN_DEPTH);
    localparam int INV_AW  = $clog2(INV_DEPTH);
    localparam int DW    = ((SAMPLE_BITS + 9 > MEAN_BITS) ? SAMPLE_BITS + 9 : MEAN_BITS) + 1;
    localparam int LB    = $clog2(MAX_BANDS) + 1;
    localparam int ACC1W = DW + WORD_BITS + LB;
    localparam int AUXW  = ACC1W - INV_SHIFT;
    localparam int MW    = (AUXW > WORD_BITS) ? AUXW : WORD_BITS;
    localparam int DISTW = DW + MW + LB;
    localparam int SCW   = ((DISTW > WORD_BITS + 2) ? DISTW : WORD_BITS + 2) + 1;
    localparam int SATW  = (SCW > SCORE_BITS) ? SCW : SCORE_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_D_ADDR, ST_D_CALC, ST_M_ADDR, ST_M_MUL, ST_M_ACC,
        ST_A_MUL, ST_A_ACC, ST_SCORE, ST_DONE
    } state_t;

    state_t state_reg;

    logic [4:0] classes_reg;
    logic [3:0] bands_reg;

    logic [MEAN_BITS-1:0]   mean_mem [MEAN_DEPTH];
    logic [WORD_BITS-1:0]   inv_mem  [INV_DEPTH];
    logic [WORD_BITS-1:0]   det_mem  [MAX_CLASSES];
    logic [WORD_BITS-1:0]   prior_mem[MAX_CLASSES];
    logic [LABEL_BITS-1:0]  label_mem[MAX_CLASSES];
    logic signed [MEAN_BITS-1:0] mean_q;
    logic signed [WORD_BITS-1:0] inv_q;

    logic [SAMPLE_BITS-1:0] pix_reg [MAX_BANDS];
    logic signed [DW-1:0]   d_reg   [MAX_BANDS];
    logic [BCW-1:0] band_cnt_reg;
    logic [BCW-1:0] nb_reg;
    logic [CCW-1:0] nc_reg;
    logic [BIW-1:0] i_reg;
    logic [BIW-1:0] j_reg;
    logic [CIW-1:0] c_reg;
    logic [CIW-1:0] best_c_reg;
    logic signed [SCW-1:0] best_reg;

    logic                  out_valid_reg;
    logic [LABEL_BITS-1:0] out_label_reg;
    logic [NUM_BITS-1:0]   out_num_reg;
    logic [SCORE_BITS-1:0] out_score_reg;

    logic [2:0]             cmd;
    logic [3:0]             slot;
    logic [2:0]             row;
    logic [2:0]             col;
    logic [WORD_BITS-1:0]   word;
    logic [SAMPLE_BITS-1:0] sample;
    logic in_xfer;
    logic wr_slot_ok;
    logic wr_row_ok;
    logic wr_col_ok;
    logic [BCW-1:0] nb_eff;
    logic [CCW-1:0] nc_eff;
    logic [MEAN_AW-1:0] mean_waddr;
    logic [MEAN_AW-1:0] mean_raddr;
    logic [INV_AW-1:0]  inv_waddr;
    logic [INV_AW-1:0]  inv_raddr;
    logic i_last;
    logic j_last;
    logic c_last;
    logic signed [DW-1:0]    d_op;
    logic signed [DW-1:0]    d_new;
    logic signed [DISTW-1:0] dist_sum;
    logic signed [SCW-1:0]   score;
    logic signed [SATW-1:0]  best_wide;
    logic [SCORE_BITS-1:0]   best_sat;
    mac_ctrl_t mac_ctrl;

    assign cmd    = s_tuser;
    assign slot   = s_tdata[3:0];
    assign row    = s_tdata[6:4];
    assign col    = s_tdata[9:7];
    assign word   = s_tdata[41:10];
    assign sample = s_tdata[42 + SAMPLE_BITS - 1:42];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    assign pready = 1'b1;
    always_comb
    begin
        case (paddr[2])
            REG_CLASSES: prdata = {27'd0, classes_reg};
            default:     prdata = {28'd0, bands_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            classes_reg <= 5'd1;
            bands_reg   <= 4'd1;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_CLASSES: classes_reg <= pwdata[4:0];
                default:     bands_reg   <= pwdata[3:0];
            endcase
        end
    end

    assign nb_eff = (bands_reg == 4'd0) ? BCW'(1) :
                    ((int'(bands_reg) > MAX_BANDS) ? BCW'(MAX_BANDS) : BCW'(bands_reg));
    assign nc_eff = (classes_reg == 5'd0) ? CCW'(1) :
                    ((int'(classes_reg) > MAX_CLASSES) ? CCW'(MAX_CLASSES) : CCW'(classes_reg));

    assign wr_slot_ok = int'(slot) < MAX_CLASSES;
    assign wr_row_ok  = int'(row) < MAX_BANDS;
    assign wr_col_ok  = int'(col) < MAX_BANDS;

    assign mean_waddr = MEAN_AW'(int'(slot) * MAX_BANDS + int'(row));
    assign inv_waddr  = INV_AW'((int'(slot) * MAX_BANDS + int'(row)) * MAX_BANDS + int'(col));
    assign mean_raddr = MEAN_AW'(int'(c_reg) * MAX_BANDS + int'(i_reg));
    assign inv_raddr  = INV_AW'((int'(c_reg) * MAX_BANDS + int'(i_reg)) * MAX_BANDS
                                + int'(j_reg));

    always_ff @(posedge clk)
    begin
        if (in_xfer && wr_slot_ok)
        begin
            case (cmd)
                CMD_MEAN:
                begin
                    if (wr_row_ok)
                    begin
                        mean_mem[mean_waddr] <= word[MEAN_BITS-1:0];
                    end
                end
                CMD_INV:
                begin
                    if (wr_row_ok && wr_col_ok)
                    begin
                        inv_mem[inv_waddr] <= word;
                    end
                end
                CMD_DET:   det_mem[CIW'(slot)]   <= word;
                CMD_PRIOR: prior_mem[CIW'(slot)] <= word;
                CMD_LABEL: label_mem[CIW'(slot)] <= word[LABEL_BITS-1:0];
                default:   ;
            endcase
        end
        mean_q <= mean_mem[mean_raddr];
        inv_q  <= inv_mem[inv_raddr];
    end

    assign i_last = (BCW'(i_reg) + BCW'(1)) == nb_reg;
    assign j_last = (BCW'(j_reg) + BCW'(1)) == nb_reg;
    assign c_last = (CCW'(c_reg) + CCW'(1)) == nc_reg;

    assign d_op  = d_reg[(state_reg == ST_A_MUL) ? j_reg : i_reg];
    assign d_new = (DW'($signed({1'b0, pix_reg[i_reg]})) <<< 8) - DW'(mean_q);
    assign score = SCW'($signed(prior_mem[c_reg])) + SCW'($signed(det_mem[c_reg]))
                   - SCW'(dist_sum >>> 1);

    always_comb
    begin
        mac_ctrl          = '0;
        mac_ctrl.mul_en   = (state_reg == ST_M_MUL) || (state_reg == ST_A_MUL);
        mac_ctrl.sel_aux  = (state_reg == ST_A_MUL);
        mac_ctrl.acc_en   = (state_reg == ST_M_ACC);
        mac_ctrl.acc_clr  = (state_reg == ST_D_ADDR) || (state_reg == ST_A_ACC);
        mac_ctrl.dist_en  = (state_reg == ST_A_ACC);
        mac_ctrl.dist_clr = (state_reg == ST_D_ADDR);
    end

    gmpc_mac #(
        .DW    (DW),
        .AUXW  (AUXW),
        .ACC1W (ACC1W),
        .DISTW (DISTW)
    ) u_mac (
        .clk      (clk),
        .ctrl     (mac_ctrl),
        .d_op     (d_op),
        .inv_word (inv_q),
        .dist_sum (dist_sum)
    );

    assign best_wide = SATW'(best_reg);
    assign best_sat  = (best_wide > SATW'(signed'({1'b0, {(SCORE_BITS - 1){1'b1}}}))) ?
                       {1'b0, {(SCORE_BITS - 1){1'b1}}} :
                       ((best_wide < SATW'(signed'({1'b1, {(SCORE_BITS - 1){1'b0}}}))) ?
                        {1'b1, {(SCORE_BITS - 1){1'b0}}} : best_wide[SCORE_BITS-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            band_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_BANDS; k++)
            begin
                pix_reg[k] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && m_tready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer && cmd == CMD_SAMPLE)
                    begin
                        if (int'(band_cnt_reg) < MAX_BANDS)
                        begin
                            pix_reg[BIW'(band_cnt_reg)] <= sample;
                        end
                        if ((band_cnt_reg + BCW'(1)) < nb_eff)
                        begin
                            band_cnt_reg <= band_cnt_reg + BCW'(1);
                        end
                        else
                        begin
                            band_cnt_reg <= '0;
                            nb_reg       <= nb_eff;
                            nc_reg       <= nc_eff;
                            c_reg        <= '0;
                            i_reg        <= '0;
                            state_reg    <= ST_D_ADDR;
                        end
                    end
                end
                ST_D_ADDR:
                begin
                    state_reg <= ST_D_CALC;
                end
                ST_D_CALC:
                begin
                    d_reg[i_reg] <= d_new;
                    if (i_last)
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= ST_M_ADDR;
                    end
                    else
                    begin
                        i_reg     <= i_reg + BIW'(1);
                        state_reg <= ST_D_ADDR;
                    end
                end
                ST_M_ADDR:
                begin
                    state_reg <= ST_M_MUL;
                end
                ST_M_MUL:
                begin
                    state_reg <= ST_M_ACC;
                end
                ST_M_ACC:
                begin
                    if (i_last)
                    begin
                        state_reg <= ST_A_MUL;
                    end
                    else
                    begin
                        i_reg     <= i_reg + BIW'(1);
                        state_reg <= ST_M_ADDR;
                    end
                end
                ST_A_MUL:
                begin
                    state_reg <= ST_A_ACC;
                end
                ST_A_ACC:
                begin
                    i_reg <= '0;
                    if (j_last)
                    begin
                        state_reg <= ST_SCORE;
                    end
                    else
                    begin
                        j_reg     <= j_reg + BIW'(1);
                        state_reg <= ST_M_ADDR;
                    end
                end
                ST_SCORE:
                begin
                    if (c_reg == '0 || score > best_reg)
                    begin
                        best_reg   <= score;
                        best_c_reg <= c_reg;
                    end
                    i_reg <= '0;
                    if (c_last)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        c_reg     <= c_reg + CIW'(1);
                        state_reg <= ST_D_ADDR;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_label_reg <= label_mem[best_c_reg];
                        out_num_reg   <= NUM_BITS'(best_c_reg);
                        out_score_reg <= best_sat;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_score_reg, out_num_reg, out_label_reg};

endmodule
